>>> design/stq_pkg.sv
// Package: shared types and constants for the sorted delay timer queue.
`timescale 1ns / 1ps

package stq_pkg;

    localparam int HANDLE_W = 16;
    localparam int TICK_W   = 32;
    localparam int KIND_W   = 2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_FIRED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FRAME = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ADDED = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FULL  = 2'd3;

    // Configuration registers
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IGNORE_THRESHOLD = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SUBSTITUTE_DELTA = 1'd1;
    localparam logic [TICK_W-1:0] IGNORE_THRESHOLD_RESET = 32'd250000;
    localparam logic [TICK_W-1:0] SUBSTITUTE_DELTA_RESET = 32'd16667;

    // Mode of an input transaction
    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_FRAME = 1'b1;

    // Command queue between front and back
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = 1;
    localparam int CMDQ_CNT_W = 2;

    typedef struct packed {
        logic                mode;
        logic [HANDLE_W-1:0] handle;
        logic [TICK_W-1:0]   delay;
        logic [TICK_W-1:0]   elapsed_ticks;
        logic [TICK_W-1:0]   paused_ticks;
    } item_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [HANDLE_W-1:0] fired_handle;
        logic [TICK_W-1:0]   applied_delta;
        logic                last;
    } result_t;

    // Classified command: value is the delay of an add or the delta of a frame
    typedef struct packed {
        logic                is_frame;
        logic [HANDLE_W-1:0] handle;
        logic [TICK_W-1:0]   value;
    } cmd_t;

    typedef enum logic {
        BK_IDLE,
        BK_FRAME
    } back_state_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_POP,
        OP_ADJUST
    } store_op_t;

endpackage

>>> design/stq_front.sv
// Front end: config registers, delta classification and the command queue.
`timescale 1ns / 1ps

module stq_front
    import stq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  item_t                  item,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]      cfg_data,
    output cmd_t                   cmd,
    input  logic                   cmd_pop,
    output logic                   cmd_valid
);

    logic [TICK_W-1:0]     threshold_reg;
    logic [TICK_W-1:0]     substitute_reg;
    cmd_t                  slot_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg;
    logic [CMDQ_CNT_W-1:0] fill_reg;
    logic [TICK_W-1:0]     diff;
    logic [TICK_W-1:0]     delta;
    cmd_t                  cmd_in;
    logic                  push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= IGNORE_THRESHOLD_RESET;
            substitute_reg <= SUBSTITUTE_DELTA_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IGNORE_THRESHOLD: threshold_reg  <= cfg_data;
                CFG_SUBSTITUTE_DELTA: substitute_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Saturate elapsed minus paused time at zero; a frame whose delta exceeds the threshold gets the substitute
    always_comb
    begin
        diff = (item.elapsed_ticks > item.paused_ticks) ?
               item.elapsed_ticks - item.paused_ticks : '0;
        delta = (diff > threshold_reg) ? substitute_reg : diff;
        cmd_in.is_frame = (item.mode == MODE_FRAME);
        cmd_in.handle   = item.handle;
        cmd_in.value    = (item.mode == MODE_FRAME) ? delta : item.delay;
    end

    assign item_ready = (fill_reg != CMDQ_CNT_W'(CMDQ_DEPTH));
    assign push       = item_valid && item_ready;
    assign cmd_valid  = (fill_reg != '0);
    assign cmd        = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (cmd_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !cmd_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (!push && cmd_pop)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

>>> design/stq_back.sv
// Back end: sorted entry store, add and frame sequencer, result register.
`timescale 1ns / 1ps

module stq_back
    import stq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int HANDLE_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      cmd,
    input  logic      cmd_valid,
    output logic      cmd_pop,
    output logic      result_valid,
    input  logic      result_ready,
    output result_t   result
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [TICK_W-1:0]      time_reg    [QUEUE_DEPTH];
    logic [HANDLE_BITS-1:0] handle_reg  [QUEUE_DEPTH];
    logic [TICK_W-1:0]      time_next   [QUEUE_DEPTH];
    logic [HANDLE_BITS-1:0] handle_next [QUEUE_DEPTH];
    logic [TICK_W-1:0]      up_time     [QUEUE_DEPTH];
    logic [HANDLE_BITS-1:0] up_handle   [QUEUE_DEPTH];
    logic [TICK_W-1:0]      down_time   [QUEUE_DEPTH];
    logic [HANDLE_BITS-1:0] down_handle [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] le;
    logic [QUEUE_DEPTH:0]   le_ext;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [TICK_W-1:0]      delta_reg;
    logic [TICK_W-1:0]      delta_next;
    back_state_t            state_reg;
    back_state_t            state_next;
    store_op_t              op;
    result_t                result_reg;
    result_t                res_next;
    logic                   out_valid_reg;
    logic                   out_free;
    logic                   emit;
    logic                   full;
    logic                   head_due;

    assign out_free = !out_valid_reg || result_ready;
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_due = (count_reg != '0) && (time_reg[0] <= delta_reg);

    // Per-entry compare: entries at or below the new delay stay in place
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            le[i] = (CNT_W'(i) < count_reg) && (time_reg[i] <= cmd.value);
        end
        le_ext = {le, 1'b1};
        up_time[0]   = cmd.value;
        up_handle[0] = HANDLE_BITS'(cmd.handle);
        for (int i = 1; i < QUEUE_DEPTH; i++)
        begin
            up_time[i]   = time_reg[i-1];
            up_handle[i] = handle_reg[i-1];
        end
        for (int i = 0; i < QUEUE_DEPTH - 1; i++)
        begin
            down_time[i]   = time_reg[i+1];
            down_handle[i] = handle_reg[i+1];
        end
        down_time[QUEUE_DEPTH-1]   = time_reg[QUEUE_DEPTH-1];
        down_handle[QUEUE_DEPTH-1] = handle_reg[QUEUE_DEPTH-1];
    end

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            time_next[i]   = time_reg[i];
            handle_next[i] = handle_reg[i];
            case (op)
                OP_INSERT:
                begin
                    if (!le[i])
                    begin
                        if (le_ext[i])
                        begin
                            time_next[i]   = cmd.value;
                            handle_next[i] = HANDLE_BITS'(cmd.handle);
                        end
                        else
                        begin
                            time_next[i]   = up_time[i];
                            handle_next[i] = up_handle[i];
                        end
                    end
                end
                OP_POP:
                begin
                    time_next[i]   = down_time[i];
                    handle_next[i] = down_handle[i];
                end
                OP_ADJUST:
                begin
                    time_next[i] = time_reg[i] - delta_reg;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg   <= time_next;
        handle_reg <= handle_next;
        delta_reg  <= delta_next;
        if (emit)
        begin
            result_reg <= res_next;
        end
    end

    // Sequencer: adds complete directly; a frame pops due entries, then adjusts
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        delta_next = delta_reg;
        op         = OP_HOLD;
        cmd_pop    = 1'b0;
        emit       = 1'b0;
        res_next   = '0;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.is_frame)
                    begin
                        delta_next = cmd.value;
                        state_next = BK_FRAME;
                    end
                    else if (full)
                    begin
                        emit          = 1'b1;
                        res_next.kind = KIND_FULL;
                        res_next.last = 1'b1;
                    end
                    else
                    begin
                        op            = OP_INSERT;
                        count_next    = count_reg + 1'b1;
                        emit          = 1'b1;
                        res_next.kind = KIND_ADDED;
                        res_next.last = 1'b1;
                    end
                end
            end
            BK_FRAME:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (head_due)
                    begin
                        op                    = OP_POP;
                        count_next            = count_reg - 1'b1;
                        res_next.kind         = KIND_FIRED;
                        res_next.fired_handle = HANDLE_W'(handle_reg[0]);
                    end
                    else
                    begin
                        op                     = OP_ADJUST;
                        res_next.kind          = KIND_FRAME;
                        res_next.applied_delta = delta_reg;
                        res_next.last          = 1'b1;
                        state_next             = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= emit || (out_valid_reg && !result_ready);
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

endmodule

>>> design/sorted_delay_timer_queue.sv
// Top level: sorted delay timer queue with decoupled front and back ends.
//
// Usage:
//   item channel (item_valid/item_ready/item) takes adds (mode 0) and frame
//   ticks (mode 1). result channel (result_valid/result_ready/result) returns
//   one result per add (accepted or rejected full), and per frame one fired
//   result for each due entry in queue order, then a frame-done result that
//   carries the applied delta. last marks the final result of a transaction.
//   cfg_we/cfg_index/cfg_data write ignore_threshold (0) and
//   substitute_delta (1); write only while the block is idle.
// Flow:
//   The front classifies a transaction in its accept cycle and parks it in a
//   two-entry command queue, so it keeps accepting while the back is busy
//   until it is full. The back sequencer inserts an add, or rejects it when
//   full, and reports it directly; a frame is loaded, then each due entry is
//   popped and reported, then survivors are adjusted and the frame reported.
// Reset and stalls:
//   Reset empties the queue and restores the default register values. The
//   stored entries are not cleared; only entries below the count are used.
//   A stalled result holds in the output register and freezes the sequencer.
`timescale 1ns / 1ps

module sorted_delay_timer_queue
    import stq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int HANDLE_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  item_t                  item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output result_t                result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]      cfg_data
);

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_pop;

    // Front: accept, classify, queue the command
    stq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop),
        .cmd_valid  (cmd_valid)
    );

    // Back: keep the sorted store, fire due entries, drive results
    stq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cmd_valid    (cmd_valid),
        .cmd_pop      (cmd_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

>>> design/stq_checker.sv
// Checker: port-level assertions for the sorted delay timer queue, with bind.
`timescale 1ns / 1ps

module stq_checker
    import stq_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    // Hold a stalled result steady
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // A fired action is never the final result of its transaction and carries no delta
    a_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == KIND_FIRED |->
            !result.last && result.applied_delta == '0)
        else $error("fired result marked last or carries a delta");

    // Every other kind closes its transaction
    a_close_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind != KIND_FIRED |-> result.last)
        else $error("closing result not marked last");

    // Add outcomes carry no handle and no delta
    a_add_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.kind == KIND_ADDED || result.kind == KIND_FULL) |->
            result.fired_handle == '0 && result.applied_delta == '0)
        else $error("add result carries payload");

endmodule

bind sorted_delay_timer_queue stq_checker u_stq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
